// ===== hdl/pixel_row_upscaler_top_assert.svh =====
// assertion macros for the pixel row upscaler top level
// expects clk and rst_n in the scope of each use
`ifndef PIXEL_ROW_UPSCALER_TOP_ASSERT_SVH
`define PIXEL_ROW_UPSCALER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pru_pkg.sv =====
// shared types and constants of the pixel row upscaler
// no dependencies; used by the top level and the emitter
`timescale 1ns / 1ps

package pru_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_FACTOR_DEF = 8;
  // most words one item may cause
  localparam int RESULT_LIMIT   = 8;
  // output rows are padded to a multiple of this many bytes
  localparam int PAD_ALIGN      = 4;
  localparam int PAD_MASK       = PAD_ALIGN - 1;

  localparam int FACTOR_W    = 4;
  localparam int WIDTH_CFG_W = 11;
  localparam int CFG_INDEX_W = 4;
  localparam int COUNT_W     = $clog2(RESULT_LIMIT + 1);
  localparam int LEFT_W      = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH = CFG_INDEX_W'(1);

  // operation codes
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       run_last;
    logic       rejected;
  } out_word_t;

  // one run of identical output words, handed to the emitter
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COUNT_W-1:0] count;
    logic               row_end;
    logic [1:0]         pad;
    logic               rejected;
  } pru_job_t;

endpackage

// ===== hdl/pixel_row_upscaler_top.sv =====
// pixel row upscaler: an accepted item passes the job stage, then the emitter's output register
// throughput: one word per cycle while out_stall is low, at most eight per item,
// one word for a rejected pixel and none for an idle replay tick; the emitter's
// single output register takes the next item as the last word of a run leaves;
// reset (synchronous, rst_n low) clears columns, replay count, valids and
// config to factor 1, width 1; the line store is not cleared
`timescale 1ns / 1ps
`include "pixel_row_upscaler_top_assert.svh"

module pixel_row_upscaler_top #(
  parameter int MAX_WIDTH  = pru_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = pru_pkg::MAX_FACTOR_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pru_pkg::in_word_t               in_word,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output pru_pkg::out_word_t              out_word,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pru_pkg::WIDTH_CFG_W-1:0] cfg_data
);

  // column counters index the line store directly
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // compare width, wide enough for both the register and the limit
  localparam int LIM_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (LIM_W > pru_pkg::WIDTH_CFG_W) ? LIM_W : pru_pkg::WIDTH_CFG_W;
  // factor ceiling: the smaller of the parameter and the per-item word limit
  localparam int FLIM  = (MAX_FACTOR < pru_pkg::RESULT_LIMIT) ? MAX_FACTOR
                                                                : pru_pkg::RESULT_LIMIT;
  localparam logic [pru_pkg::FACTOR_W-1:0] FLIM_V = pru_pkg::FACTOR_W'(FLIM);
  localparam logic [CMP_W-1:0]             WLIM_V = CMP_W'(MAX_WIDTH);

  // config registers
  logic [pru_pkg::FACTOR_W-1:0]    scale_factor_r;
  logic [pru_pkg::WIDTH_CFG_W-1:0] source_width_r;

  // row state
  logic [COL_W-1:0]           write_column_r, write_column_nxt;
  logic [COL_W-1:0]           replay_column_r, replay_column_nxt;
  logic [pru_pkg::LEFT_W-1:0] replays_left_r, replays_left_nxt;

  // job stage between accept and emitter
  logic              p1_valid_r, p1_valid_nxt;
  logic              p1_from_ram_r;
  pru_pkg::pru_job_t p1_job_r;
  pru_pkg::pru_job_t job_new;
  pru_pkg::pru_job_t job_emit;
  logic              job_take;

  // effective config and row decisions
  logic [pru_pkg::FACTOR_W-1:0] f_eff;
  logic [CMP_W-1:0]             w_eff;
  logic [CMP_W-1:0]             sw_ext;
  logic [CMP_W-1:0]             col_plus;
  logic [COL_W-1:0]             col_sel;
  logic [3:0]                   pad_prod;
  logic [1:0]                   pad_row;
  logic                         row_done;

  logic acc;
  logic is_pix;
  logic pending;
  logic reject;
  logic pix_write;
  logic replay_read;
  logic job_new_valid;

  logic [23:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r <= pru_pkg::FACTOR_W'(1);
      source_width_r <= pru_pkg::WIDTH_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pru_pkg::REG_SCALE_FACTOR: scale_factor_r <= cfg_data[pru_pkg::FACTOR_W-1:0];
        pru_pkg::REG_SOURCE_WIDTH: source_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp factor to 1..FLIM and width to 1..MAX_WIDTH
  always_comb begin
    f_eff = scale_factor_r;
    if (scale_factor_r == '0) begin
      f_eff = pru_pkg::FACTOR_W'(1);
    end else if (scale_factor_r > FLIM_V) begin
      f_eff = FLIM_V;
    end
    sw_ext = CMP_W'(source_width_r);
    w_eff  = sw_ext;
    if (sw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (sw_ext > WLIM_V) begin
      w_eff = WLIM_V;
    end
  end

  // padding only depends on the low two bits of width and factor
  assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, f_eff[1:0]};
  assign pad_row  = 2'(pad_prod & 4'(pru_pkg::PAD_MASK));

  assign acc         = in_valid && !in_stall;
  assign is_pix      = in_word.operation == pru_pkg::OP_PIXEL;
  assign pending     = replays_left_r != '0;
  assign reject      = is_pix && pending;
  // writes only happen with no replays pending, reads only with some,
  // so the store never sees a read and a write of one entry in a cycle
  assign pix_write   = acc && is_pix && !pending;
  assign replay_read = acc && !is_pix && pending;
  // an idle replay tick is taken and dropped
  assign job_new_valid = acc && (is_pix || pending);

  assign col_sel  = is_pix ? write_column_r : replay_column_r;
  assign col_plus = CMP_W'(col_sel) + CMP_W'(1);
  // a shrunk width ends the row at any column beyond it
  assign row_done = col_plus >= w_eff;

  always_comb begin
    write_column_nxt  = write_column_r;
    replay_column_nxt = replay_column_r;
    replays_left_nxt  = replays_left_r;
    if (pix_write) begin
      if (row_done) begin
        write_column_nxt  = '0;
        replay_column_nxt = '0;
        replays_left_nxt  = pru_pkg::LEFT_W'(f_eff - pru_pkg::FACTOR_W'(1));
      end else begin
        write_column_nxt = COL_W'(col_plus);
      end
    end else if (replay_read) begin
      if (row_done) begin
        replay_column_nxt = '0;
        replays_left_nxt  = replays_left_r - pru_pkg::LEFT_W'(1);
      end else begin
        replay_column_nxt = COL_W'(col_plus);
      end
    end
  end

  // run description for the accepted item; replay pixels come from the store
  always_comb begin
    job_new.red      = reject ? 8'd0 : in_word.red;
    job_new.green    = reject ? 8'd0 : in_word.green;
    job_new.blue     = reject ? 8'd0 : in_word.blue;
    job_new.count    = reject ? pru_pkg::COUNT_W'(1) : pru_pkg::COUNT_W'(f_eff);
    job_new.row_end  = !reject && row_done;
    job_new.pad      = (!reject && row_done) ? pad_row : 2'd0;
    job_new.rejected = reject;
  end

  pru_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (pix_write),
    .waddr(write_column_r),
    .wdata({in_word.red, in_word.green, in_word.blue}),
    .re   (replay_read),
    .raddr(replay_column_r),
    .rdata(ram_rdata)
  );

  // the job stage holds while the emitter is busy; no new read is issued
  // then, so the store's read register keeps the replay pixel
  assign in_stall = p1_valid_r && !job_take;

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (job_take || !p1_valid_r) begin
      p1_valid_nxt = job_new_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_column_r  <= '0;
      replay_column_r <= '0;
      replays_left_r  <= '0;
      p1_valid_r      <= 1'b0;
      p1_from_ram_r   <= 1'b0;
    end else begin
      write_column_r  <= write_column_nxt;
      replay_column_r <= replay_column_nxt;
      replays_left_r  <= replays_left_nxt;
      p1_valid_r      <= p1_valid_nxt;
      if (acc) begin
        p1_from_ram_r <= !is_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_job_r <= job_new;
    end
  end

  always_comb begin
    job_emit = p1_job_r;
    if (p1_from_ram_r) begin
      job_emit.red   = ram_rdata[23:16];
      job_emit.green = ram_rdata[15:8];
      job_emit.blue  = ram_rdata[7:0];
    end
  end

  pru_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(p1_valid_r),
    .job      (job_emit),
    .job_take (job_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // a rejected word stands alone and carries no row end
  `PRU_ASSERT_NOW(a_reject_alone, out_valid && out_word.rejected,
    out_word.run_last && !out_word.row_end, "rejected word not a lone run")
  // no pixel is written while replays are pending, so the write column rests at zero
  `PRU_ASSERT_NOW(a_replay_col, replays_left_r != '0, write_column_r == '0,
    "write column moved during replays")
  // an accepted replay with replays pending becomes a store-sourced job
  `PRU_ASSERT_NEXT(a_replay_job, replay_read, p1_valid_r && p1_from_ram_r,
    "replay tick lost its job")

endmodule

// ===== hdl/pru_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pru_emitter.sv =====
// run emitter: sends one pixel count times through a registered output
// depends on pru_pkg
`timescale 1ns / 1ps

module pru_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  pru_pkg::pru_job_t  job,
  output logic               job_take,
  output logic               out_valid,
  input  logic               out_stall,
  output pru_pkg::out_word_t out_word
);

  logic                       out_valid_r, out_valid_nxt;
  pru_pkg::out_word_t         out_word_r, out_word_nxt;
  logic [pru_pkg::LEFT_W-1:0] run_left_r, run_left_nxt;
  logic                       run_row_end_r, run_row_end_nxt;
  logic [1:0]                 run_pad_r, run_pad_nxt;

  logic take_out;
  logic more;
  logic last_next;

  assign take_out  = out_valid_r && !out_stall;
  assign more      = run_left_r != '0;
  assign last_next = run_left_r == pru_pkg::LEFT_W'(1);
  assign job_take  = job_valid && (!out_valid_r || (take_out && !more));

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_word_nxt    = out_word_r;
    run_left_nxt    = run_left_r;
    run_row_end_nxt = run_row_end_r;
    run_pad_nxt     = run_pad_r;
    if (take_out && more) begin
      // next copy of the same pixel
      run_left_nxt           = run_left_r - pru_pkg::LEFT_W'(1);
      out_word_nxt.run_last  = last_next;
      out_word_nxt.row_end   = last_next && run_row_end_r;
      out_word_nxt.pad_bytes = (last_next && run_row_end_r) ? run_pad_r : 2'd0;
    end else if (job_take) begin
      out_valid_nxt          = 1'b1;
      run_left_nxt           = pru_pkg::LEFT_W'(job.count - pru_pkg::COUNT_W'(1));
      run_row_end_nxt        = job.row_end;
      run_pad_nxt            = job.pad;
      out_word_nxt.out_blue  = job.blue;
      out_word_nxt.out_green = job.green;
      out_word_nxt.out_red   = job.red;
      out_word_nxt.run_last  = job.count == pru_pkg::COUNT_W'(1);
      out_word_nxt.row_end   = (job.count == pru_pkg::COUNT_W'(1)) && job.row_end;
      out_word_nxt.pad_bytes = ((job.count == pru_pkg::COUNT_W'(1)) && job.row_end) ?
                               job.pad : 2'd0;
      out_word_nxt.rejected  = job.rejected;
    end else if (take_out) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_left_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      run_left_r  <= run_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r    <= out_word_nxt;
    run_row_end_r <= run_row_end_nxt;
    run_pad_r     <= run_pad_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for pixel_row_upscaler_top: directed rows, then random rows
// with noise, random gaps and stalls; depends on pru_pkg and the top-level rtl only
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  // an idle replay tick is taken with no word to show for it
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int COL_W          = $clog2(pru_pkg::MAX_WIDTH_DEF);
  localparam int CFG_W          = pru_pkg::WIDTH_CFG_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  pru_pkg::in_word_t               in_word = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  pru_pkg::out_word_t              out_word;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pru_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]                cfg_data = '0;

  pixel_row_upscaler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // source words waiting for the driver, upscaled words waiting for the dut
  pru_pkg::in_word_t  source_words[$];
  pru_pkg::out_word_t upscaled_words[$];
  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned mismatches = 0;

  // ---------------------------------------------------------------------------
  // upscaler mirror: register copies plus line store and row/replay counters
  // ---------------------------------------------------------------------------
  logic [pru_pkg::FACTOR_W-1:0] scale_cfg = pru_pkg::FACTOR_W'(1);
  logic [CFG_W-1:0]             width_cfg = CFG_W'(1);
  logic [23:0]                  row_store [pru_pkg::MAX_WIDTH_DEF];
  int unsigned                  fill_col = 0;
  int unsigned                  replay_col = 0;
  int unsigned                  rows_pending = 0;
  // columns 0..written_cols-1 hold a pixel since reset
  int unsigned                  written_cols = 0;

  // factor 0 behaves as 1, anything past eight is clamped
  function automatic int unsigned eff_factor();
    int unsigned f;
    f = 32'(scale_cfg);
    if (f < 1) f = 1;
    if (f > pru_pkg::MAX_FACTOR_DEF) f = pru_pkg::MAX_FACTOR_DEF;
    if (f > pru_pkg::RESULT_LIMIT) f = pru_pkg::RESULT_LIMIT;
    return f;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_cfg);
    if (w < 1) w = 1;
    if (w > pru_pkg::MAX_WIDTH_DEF) w = pru_pkg::MAX_WIDTH_DEF;
    return w;
  endfunction

  // one stored pixel repeated factor times; the last copy may close the row
  function automatic void emit_run(logic [23:0] pix, bit at_row_end);
    int unsigned        f;
    logic [1:0]         pad;
    pru_pkg::out_word_t word;
    f = eff_factor();
    pad = 2'((eff_width() * f) & pru_pkg::PAD_MASK);
    for (int unsigned k = 0; k < f; k++) begin
      word.out_blue  = pix[7:0];
      word.out_green = pix[15:8];
      word.out_red   = pix[23:16];
      word.row_end   = (k + 1 == f) && at_row_end;
      word.pad_bytes = ((k + 1 == f) && at_row_end) ? pad : 2'd0;
      word.run_last  = (k + 1 == f);
      word.rejected  = 1'b0;
      upscaled_words.push_back(word);
    end
  endfunction

  function automatic void upscale_step(pru_pkg::in_word_t item);
    int unsigned        f;
    int unsigned        w;
    bit                 row_done;
    logic [23:0]        pix;
    pru_pkg::out_word_t turned_away;
    f = eff_factor();
    w = eff_width();
    if (item.operation == pru_pkg::OP_PIXEL) begin
      // replays still owed: the pixel is turned away, nothing moves
      if (rows_pending != 0) begin
        turned_away = '0;
        turned_away.run_last = 1'b1;
        turned_away.rejected = 1'b1;
        upscaled_words.push_back(turned_away);
        return;
      end
      pix = {item.red, item.green, item.blue};
      row_store[fill_col[COL_W-1:0]] = pix;
      if (fill_col + 1 > written_cols) written_cols = fill_col + 1;
      // a shrunk width ends the row at any column past its last one
      row_done = (fill_col + 1 >= w);
      if (row_done) begin
        fill_col = 0;
        replay_col = 0;
        rows_pending = (f - 1) & 7;
      end else begin
        fill_col = (fill_col + 1) % pru_pkg::MAX_WIDTH_DEF;
      end
      emit_run(pix, row_done);
    end else begin
      // idle tick: no word, no change
      if (rows_pending == 0) return;
      pix = row_store[replay_col[COL_W-1:0]];
      row_done = (replay_col + 1 >= w);
      if (row_done) begin
        replay_col = 0;
        rows_pending = rows_pending - 1;
      end else begin
        replay_col = (replay_col + 1) % pru_pkg::MAX_WIDTH_DEF;
      end
      emit_run(pix, row_done);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling: mostly short pauses, now and then long, with quiet stretches
  // ---------------------------------------------------------------------------
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  function automatic int unsigned pick_pause(ref bit quiet);
    int unsigned r;
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds source words, mirrors each accepted word into the predictor
  // ---------------------------------------------------------------------------
  int unsigned gap_run = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_run = 0;
    end else begin
      if (in_valid && !in_stall) begin
        upscale_step(in_word);
        accepted++;
      end
      // payload holds while stalled; a new word only goes out on a free slot
      if (!in_valid || !in_stall) begin
        if (gap_run != 0 || source_words.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_run != 0) gap_run--;
        end else begin
          in_word  <= source_words.pop_front();
          in_valid <= 1'b1;
          gap_run = pick_pause(in_quiet);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each accepted word against the oldest one due
  // ---------------------------------------------------------------------------
  int unsigned        stall_run = 0;
  pru_pkg::out_word_t due;

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (upscaled_words.size() == 0) begin
          $error("word %h arrived with nothing due", out_word);
          mismatches++;
        end else begin
          due = upscaled_words.pop_front();
          check_field("out_blue",  due.out_blue,  out_word.out_blue);
          check_field("out_green", due.out_green, out_word.out_green);
          check_field("out_red",   due.out_red,   out_word.out_red);
          check_field("row_end",   8'(due.row_end),   8'(out_word.row_end));
          check_field("pad_bytes", 8'(due.pad_bytes), 8'(out_word.pad_bytes));
          check_field("run_last",  8'(due.run_last),  8'(out_word.run_last));
          check_field("rejected",  8'(due.rejected),  8'(out_word.rejected));
        end
      end
      if (stall_run != 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        stall_run = pick_pause(out_quiet);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no word moving on any channel ends the run
  // ---------------------------------------------------------------------------
  int unsigned silent_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      silent_cycles <= 0;
    end else if (silent_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic op, logic [23:0] pix);
    source_words.push_back(pru_pkg::in_word_t'{operation: op, blue: pix[7:0],
                                               green: pix[15:8], red: pix[23:16]});
    queued++;
  endtask

  // row pixels; the odd idle tick slips in since no replay is owed here
  task automatic queue_pixels(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) queue_item(pru_pkg::OP_REPLAY, 24'($urandom));
      queue_item(pru_pkg::OP_PIXEL, 24'($urandom));
    end
  endtask

  // replay ticks; the odd pixel slips in ahead of a tick and gets turned away
  task automatic queue_ticks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) queue_item(pru_pkg::OP_PIXEL, 24'($urandom));
      queue_item(pru_pkg::OP_REPLAY, 24'($urandom));
    end
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic [pru_pkg::CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == pru_pkg::REG_SCALE_FACTOR) scale_cfg = value[pru_pkg::FACTOR_W-1:0];
    else if (index == pru_pkg::REG_SOURCE_WIDTH) width_cfg = value;
  endtask

  // all words sent and accepted and all due words back, then a quiet settling wait
  task automatic settle();
    do @(posedge clk);
    while (accepted != queued || upscaled_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned f;
    int unsigned w;
    int unsigned raw_w;
    int unsigned k;
    int unsigned start;
    int unsigned budget;
    int unsigned random_items;
    random_items = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: factor 1, width 1; byte extremes and an idle tick
    queue_item(pru_pkg::OP_PIXEL, 24'h000000);
    queue_item(pru_pkg::OP_PIXEL, 24'hFFFFFF);
    queue_item(pru_pkg::OP_PIXEL, 24'hC35AA5);
    queue_item(pru_pkg::OP_REPLAY, 24'hFFFFFF);
    settle();

    // zero factor and zero width both behave as one
    write_reg(pru_pkg::REG_SCALE_FACTOR, CFG_W'(0));
    write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(0));
    queue_item(pru_pkg::OP_PIXEL, 24'h030201);
    queue_item(pru_pkg::OP_REPLAY, 24'h000000);
    settle();

    // factor 3 on a two-pixel row: a pixel turned away mid-replay,
    // two replayed rows, then an idle tick
    write_reg(pru_pkg::REG_SCALE_FACTOR, CFG_W'(3));
    write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(2));
    queue_item(pru_pkg::OP_PIXEL, 24'h123456);
    queue_item(pru_pkg::OP_PIXEL, 24'hABCDEF);
    queue_item(pru_pkg::OP_PIXEL, 24'h777777);
    repeat (4) queue_item(pru_pkg::OP_REPLAY, 24'h000000);
    queue_item(pru_pkg::OP_REPLAY, 24'h5A5A5A);
    settle();

    // oversized factor clamps to eight; stop halfway through a six-pixel row
    write_reg(pru_pkg::REG_SCALE_FACTOR, CFG_W'(15));
    write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(6));
    repeat (3) queue_item(pru_pkg::OP_PIXEL, 24'($urandom));
    settle();

    // width shrunk below the current column: next pixel closes the row
    write_reg(pru_pkg::REG_SCALE_FACTOR, CFG_W'(2));
    write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(2));
    queue_item(pru_pkg::OP_PIXEL, 24'h0F0F0F);
    repeat (2) queue_item(pru_pkg::OP_REPLAY, 24'h000000);
    settle();

    // oversized width clamps to the full line store: a short run of pixels
    // stays open, the first random phase closes it under a narrow width
    write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(2047));
    queue_pixels(5);
    settle();

    // random phases: mostly whole rows with their replays, some noise,
    // and about half the phases cut off partway through a row
    while (random_items < RANDOM_ITEMS) begin
      k = $urandom_range(0, 19);
      write_reg(pru_pkg::REG_SCALE_FACTOR,
                CFG_W'((k == 0) ? 0 : (k == 1) ? $urandom_range(9, 15) :
                       $urandom_range(1, 8)));
      k = $urandom_range(0, 19);
      raw_w = (k == 0) ? 0 : (k == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      w = (raw_w == 0) ? 1 : raw_w;
      // replays still owed must stay inside columns already holding a pixel
      if (rows_pending != 0 && w > written_cols) raw_w = written_cols;
      write_reg(pru_pkg::REG_SOURCE_WIDTH, CFG_W'(raw_w));
      f = eff_factor();
      w = eff_width();
      start = queued;

      // finish whatever the last phase left open, under the new settings
      if (rows_pending != 0) begin
        queue_ticks(((replay_col + 1 >= w) ? 1 : w - replay_col) + (rows_pending - 1) * w);
      end else if (fill_col != 0) begin
        queue_pixels((fill_col + 1 >= w) ? 1 : w - fill_col);
        queue_ticks((f - 1) * w);
      end

      budget = $urandom_range(20, 60);
      while (queued - start < budget) begin
        queue_pixels(w);
        queue_ticks((f - 1) * w);
      end
      if ($urandom_range(0, 1) == 1) begin
        k = $urandom_range(1, w);
        queue_pixels(k);
        if (k == w) queue_ticks($urandom_range(0, (f - 1) * w));
      end
      random_items += queued - start;
      settle();
    end

    if (mismatches == 0 && upscaled_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
